// ===== hdl/ilst_pkg.sv =====
`timescale 1ns / 1ps

package ilst_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_READ     = 3'd3,
    OP_CONTAINS = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    logic app;  // write value at the tail
    logic ins;  // open a gap at the index and write value there
    logic rem;  // close the gap at the index
    logic cap;  // take a snapshot of compare and select for the current request
  } ilst_ctl_t;

endpackage

// ===== hdl/indexed_ordered_list.sv =====
`timescale 1ns / 1ps

// Channel  Ports                                           Handshake
// request  in_operation, in_index, in_value               start & !busy
// result   out_read_value, out_found, out_count, out_status  out_valid, one cycle
//
// For each request the row of cells shifts and snapshots its
// compare and select results at the accepting edge, and the OR reduction over
// the row is registered into the result on the next edge. busy is high for the
// one cycle in between. Reset empties the list; entry contents are not cleared.
// The receiver cannot stall, so results are never held back.
module indexed_ordered_list #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_operation,
  input  logic [$clog2(DEPTH+1)-1:0]        in_index,
  input  logic signed [ilst_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [ilst_pkg::DATA_W-1:0] out_read_value,
  output logic                              out_found,
  output logic [$clog2(DEPTH+1)-1:0]        out_count,
  output logic [1:0]                        out_status
);
  import ilst_pkg::*;

  localparam int IW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_V = IW'(DEPTH);

  logic              accept;
  logic [IW-1:0]     count_r, count_nxt;
  status_t           status_nxt, status_r;
  logic [2:0]        op_r;
  logic              pend_r;
  ilst_ctl_t         ctl;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_sel  [DEPTH];
  logic [DEPTH-1:0]  cell_hit;
  logic              any_hit;
  logic [DATA_W-1:0] sel_or;

  logic              out_valid_r;
  logic [DATA_W-1:0] rd_r;
  logic              found_r;
  logic [IW-1:0]     out_count_r;
  status_t           out_status_r;

  assign accept = start && !pend_r;
  assign busy   = pend_r;

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    ctl        = '0;
    ctl.cap    = accept;
    case (in_operation)
      OP_APPEND: begin
        if (count_r == DEPTH_V) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.app   = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_INSERT: begin
        if (in_index > count_r) begin
          status_nxt = ST_RANGE;
        end else if (count_r == DEPTH_V) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.ins   = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (in_index >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          ctl.rem   = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ: begin
        if (in_index >= count_r) begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = in_value;
    end else begin : g_body
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_data[g+1];
    end
    ilst_cell #(
      .DEPTH (DEPTH),
      .POS   (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (in_index),
      .cnt     (count_r),
      .value   (in_value),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .hit_o   (cell_hit[g]),
      .sel_o   (cell_sel[g])
    );
  end

  ilst_reduce #(
    .DEPTH (DEPTH)
  ) u_reduce (
    .hit     (cell_hit),
    .sel     (cell_sel),
    .any_hit (any_hit),
    .sel_or  (sel_or)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= accept;
      out_valid_r <= pend_r;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_operation;
      status_r    <= status_nxt;
      out_count_r <= count_nxt;
    end
    if (pend_r) begin
      rd_r         <= ((op_r == OP_READ) && (status_r == ST_OK)) ? sel_or : '0;
      found_r      <= (op_r == OP_CONTAINS) && any_hit;
      out_status_r <= status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_r;
  assign out_found      = found_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_V) else $error("entry count beyond depth");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy held for more than one cycle");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid) else $error("result not delivered two cycles after request");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_read_value == '0) && !out_found))
    else $error("failed request reports data");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1)
                || (count_r == $past(count_r) - 1'b1)))
    else $error("entry count moved by more than one");

endmodule

// ===== hdl/ilst_cell.sv =====
`timescale 1ns / 1ps

module ilst_cell #(
  parameter int DEPTH = 64,
  parameter int POS   = 0
) (
  input  logic                            clk,
  input  ilst_pkg::ilst_ctl_t             ctl,
  input  logic [$clog2(DEPTH+1)-1:0]      idx,
  input  logic [$clog2(DEPTH+1)-1:0]      cnt,
  input  logic [ilst_pkg::DATA_W-1:0]     value,
  input  logic [ilst_pkg::DATA_W-1:0]     left_i,
  input  logic [ilst_pkg::DATA_W-1:0]     right_i,
  output logic [ilst_pkg::DATA_W-1:0]     data_o,
  output logic                            hit_o,
  output logic [ilst_pkg::DATA_W-1:0]     sel_o
);
  import ilst_pkg::*;

  localparam int IW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] POS_V  = IW'(POS);
  localparam logic [IW-1:0] POS_P1 = IW'(POS + 1);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              hit_r;
  logic [DATA_W-1:0] sel_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.app && (POS_V == cnt)) begin
      data_nxt = value;
    end else if (ctl.ins) begin
      if (POS_V == idx) begin
        data_nxt = value;
      end else if ((POS_V > idx) && (POS_V <= cnt)) begin
        data_nxt = left_i;
      end
    end else if (ctl.rem && (POS_V >= idx) && (POS_P1 < cnt)) begin
      data_nxt = right_i;
    end
  end

  // The snapshot is taken from the contents before this request changes them.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.cap) begin
      hit_r <= (POS_V < cnt) && (data_r == value);
      sel_r <= (POS_V == idx) ? data_r : '0;
    end
  end

  assign data_o = data_r;
  assign hit_o  = hit_r;
  assign sel_o  = sel_r;

endmodule

// ===== hdl/ilst_reduce.sv =====
`timescale 1ns / 1ps

module ilst_reduce #(
  parameter int DEPTH = 64
) (
  input  logic [DEPTH-1:0]              hit,
  input  logic [ilst_pkg::DATA_W-1:0]   sel [DEPTH],
  output logic                          any_hit,
  output logic [ilst_pkg::DATA_W-1:0]   sel_or
);
  import ilst_pkg::*;

  // At most one cell holds a non-zero selection, so an OR picks it out.
  always_comb begin
    sel_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_or = sel_or | sel[i];
    end
  end

  assign any_hit = |hit;

endmodule
